/* src/s2v_pkg.sv */
// Shared types, constants and elaboration-time table functions for the slope to Vs30 block.
package s2v_pkg;

  localparam int SLOPE_W   = 24;
  localparam int WEIGHT_W  = 17;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int VS_W      = 16;

  localparam int ROWS_MAX       = 16;
  localparam int ROW_IDX_W      = $clog2(ROWS_MAX);
  localparam int TABLE_ROWS_DEF = 6;
  localparam int Q_DEPTH_DEF    = 4;

  // Log values are signed Q16 and stay within +/- 2^22.
  localparam int LW     = 23;
  localparam int DW     = LW + 1;
  localparam int PW     = 2 * DW;
  localparam int EW     = PW + 2;
  localparam int MW     = 31;
  localparam int FRAC_W = 16;
  localparam int INT_W  = 5;
  localparam int IPW    = 8;
  localparam int VQ8_W  = 20;
  localparam int VWIDE_W = 34;

  localparam logic [VQ8_W-1:0]    Q8_CAP     = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  localparam logic [CFG_W-1:0] WATER_RST = 12'd600;
  localparam logic [CFG_W-1:0] FLOOR_RST = 12'd180;
  localparam logic [CFG_W-1:0] CEIL_RST  = 12'd900;

  localparam logic [CFG_IDX_W-1:0] REG_WATER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CEIL  = 2'd2;

  typedef enum logic [1:0] {MODE_ROW, MODE_BELOW, MODE_ABOVE} mode_t;

  typedef struct packed {
    logic                land;
    logic                zero;
    logic [WEIGHT_W-1:0] weight;
  } tag_t;

  typedef struct packed {
    mode_t                mode;
    logic [ROW_IDX_W-1:0] row;
  } pick_t;

  typedef struct packed {
    tag_t                   tag;
    logic signed [LW-1:0]   lg;
    pick_t                  pick_cr;
    pick_t                  pick_ac;
  } item_t;

  typedef logic [ROWS_MAX-1:0][3:0][LW-1:0] logtab_t;
  typedef int unsigned rowtab_t [ROWS_MAX][4];

  // Columns: v0, v1 in m/s; s0, s1 in units of 1e-5.
  localparam rowtab_t CRATON_ROWS = '{
    '{180, 240, 2, 200}, '{240, 300, 200, 400}, '{300, 360, 400, 720},
    '{360, 490, 720, 1300}, '{490, 620, 1300, 1800}, '{620, 760, 1800, 2500},
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}};
  localparam rowtab_t ACTIVE_ROWS = '{
    '{180, 240, 30, 350}, '{240, 300, 350, 1000}, '{300, 360, 1000, 1800},
    '{360, 490, 1800, 5000}, '{490, 620, 5000, 10000}, '{620, 760, 10000, 14000},
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}};

  // Bit-exact Q16 log2 by repeated squaring, used only for constants.
  function automatic longint log2_q16(longint unsigned x);
    int p;
    longint unsigned m;
    longint frac;
    p = 63;
    frac = 0;
    if (x == 0) return 0;
    while (x[p] == 1'b0) p--;
    if (p <= 30) m = x << (30 - p);
    else m = x >> (p - 30);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(p) * 65536 + frac;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rem;
    res = 0;
    rem = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in Q30.
  function automatic logic [MW-1:0] root_q30(int k);
    longint unsigned r;
    r = 64'd2 << 30;
    for (int i = 1; i <= k; i++) r = sqrt_floor(r << 30);
    return r[MW-1:0];
  endfunction

  function automatic logtab_t make_logs(bit active);
    logtab_t t;
    longint ten5;
    longint l;
    int unsigned v;
    ten5 = log2_q16(100000);
    for (int r = 0; r < ROWS_MAX; r++) begin
      for (int c = 0; c < 4; c++) begin
        v = active ? ACTIVE_ROWS[r][c] : CRATON_ROWS[r][c];
        l = log2_q16(longint'(v));
        if (c >= 2) l = l - ten5;
        t[r][c] = l[LW-1:0];
      end
    end
    return t;
  endfunction

endpackage

/* src/s2v_front.sv */
// Front end: accepts pixels, takes the slope log and picks a row in each table.
module s2v_front #(
  parameter int TABLE_ROWS = s2v_pkg::TABLE_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [s2v_pkg::SLOPE_W-1:0]     slope,
  input  logic                            land_flag,
  input  logic [s2v_pkg::WEIGHT_W-1:0]    craton_weight,
  input  logic                            adv,
  output logic                            busy,
  output logic                            out_valid,
  output s2v_pkg::item_t                  out_item
);
  import s2v_pkg::*;

  localparam int NSQ = FRAC_W;
  localparam logtab_t LOG_CR = make_logs(1'b0);
  localparam logtab_t LOG_AC = make_logs(1'b1);
  localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(TABLE_ROWS - 1);
  localparam logic signed [LW-1:0] LG_BIAS = LW'(20 * 65536);

  logic               v_r   [0:NSQ];
  logic [MW-1:0]      m_r   [0:NSQ];
  logic [FRAC_W-1:0]  f_r   [0:NSQ];
  logic [INT_W-1:0]   p_r   [0:NSQ];
  tag_t               tag_r [0:NSQ];
  logic [MW-1:0]      sq_m  [1:NSQ];
  logic               sq_b  [1:NSQ];

  logic                 lv;
  logic signed [LW-1:0] lg;
  tag_t                 ltag;

  logic [INT_W-1:0]    p0;
  logic [MW-1:0]       m0;
  logic [WEIGHT_W-1:0] w0;

  function automatic pick_t pick(logtab_t t, logic signed [LW-1:0] x, logic z);
    pick_t r;
    r.mode = MODE_ROW;
    r.row = LAST_ROW;
    if (z || x <= signed'(t[0][2])) begin
      r.mode = MODE_BELOW;
      r.row = '0;
    end else if (x >= signed'(t[TABLE_ROWS-1][3])) begin
      r.mode = MODE_ABOVE;
    end else begin
      for (int j = TABLE_ROWS - 1; j >= 0; j--) begin
        if (x <= signed'(t[j][3])) r.row = ROW_IDX_W'(j);
      end
    end
    return r;
  endfunction

  assign busy = !adv;

  // Normalize the slope so that its top set bit lands on bit 30.
  always_comb begin
    p0 = '0;
    for (int i = 0; i < SLOPE_W; i++) begin
      if (slope[i]) p0 = INT_W'(i);
    end
    m0 = MW'(slope) << (INT_W'(30) - p0);
    w0 = (craton_weight > WEIGHT_ONE) ? WEIGHT_ONE : craton_weight;
  end

  for (genvar k = 1; k <= NSQ; k++) begin : g_sq
    logic [2*MW-1:0] sq;
    assign sq = m_r[k-1] * m_r[k-1];
    assign sq_b[k] = sq[2*MW-1];
    assign sq_m[k] = sq[2*MW-1] ? sq[2*MW-1:MW] : sq[2*MW-2:MW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NSQ; k++) v_r[k] <= 1'b0;
      lv <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_r[0] <= start;
      for (int k = 1; k <= NSQ; k++) v_r[k] <= v_r[k-1];
      lv <= v_r[NSQ];
      out_valid <= lv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0]   <= m0;
      f_r[0]   <= '0;
      p_r[0]   <= p0;
      tag_r[0] <= '{land: land_flag, zero: (slope == '0), weight: w0};
      for (int k = 1; k <= NSQ; k++) begin
        m_r[k]   <= sq_m[k];
        f_r[k]   <= {f_r[k-1][FRAC_W-2:0], sq_b[k]};
        p_r[k]   <= p_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
      lg   <= signed'(LW'({p_r[NSQ], f_r[NSQ]})) - LG_BIAS;
      ltag <= tag_r[NSQ];
      out_item <= '{tag: ltag, lg: lg,
                    pick_cr: pick(LOG_CR, lg, ltag.zero),
                    pick_ac: pick(LOG_AC, lg, ltag.zero)};
    end
  end

endmodule

/* src/s2v_fifo.sv */
// Short queue between the front end and the two interpolation lanes.
module s2v_fifo #(
  parameter int DEPTH = s2v_pkg::Q_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  s2v_pkg::item_t  din,
  input  logic            pop,
  output s2v_pkg::item_t  dout,
  output logic            full,
  output logic            empty
);
  import s2v_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CW-1:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  assign dout  = mem[rp];
  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);

endmodule

/* src/s2v_lane.sv */
// One table lane: row interpolation in log space, pipelined divide, exp2 and clamping.
module s2v_lane #(
  parameter bit ACTIVE = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  s2v_pkg::tag_t                 in_tag,
  input  logic signed [s2v_pkg::LW-1:0] in_lg,
  input  s2v_pkg::pick_t                in_pick,
  input  logic [s2v_pkg::CFG_W-1:0]     vs30_floor,
  input  logic [s2v_pkg::CFG_W-1:0]     vs30_ceiling,
  output logic                          out_valid,
  output s2v_pkg::tag_t                 out_tag,
  output logic [s2v_pkg::VQ8_W-1:0]     out_v
);
  import s2v_pkg::*;

  localparam logtab_t LOGS = make_logs(ACTIVE);
  localparam int DIV_LAST = 2 + PW;
  localparam int E0S = DIV_LAST + 1;
  localparam int E1S = E0S + 1;
  localparam int X1S = E1S + FRAC_W + 1;
  localparam int X2S = X1S + 1;
  localparam int NST = X2S + 1;
  localparam logic signed [EW-1:0] E_HI = EW'(24 * 65536);
  localparam logic signed [EW-1:0] E_LO = EW'(-64 * 65536);
  localparam logic signed [IPW-1:0] IP_SHIFT = IPW'(22);

  typedef struct packed {
    tag_t  tag;
    mode_t mode;
  } sb_t;

  logic vld [0:NST-1];
  sb_t  sb  [0:NST-1];

  // Stage A: row constants and differences.
  logic signed [LW-1:0] ca, cb, cc, cd;
  logic signed [LW-1:0] a_A;
  logic signed [DW-1:0] ba_A, df_A, den_A;
  // Stage M: product.
  logic signed [LW-1:0] a_M;
  logic signed [PW-1:0] prod_M;
  logic signed [DW-1:0] den_M;
  logic                 dpos_M;
  // Divider, index 0 is the sign/magnitude stage.
  logic [PW-1:0]         x_d    [0:PW];
  logic [DW-1:0]         r_d    [0:PW];
  logic [DW-1:0]         den_d  [0:PW];
  logic signed [LW-1:0]  a_d    [0:PW];
  logic                  neg_d  [0:PW];
  logic                  dpos_d [0:PW];
  logic [PW-1:0]         x_n    [1:PW];
  logic [DW-1:0]         r_n    [1:PW];
  // Exponent.
  logic signed [EW-1:0]  e_E;
  logic signed [EW-1:0]  qv;
  logic [MW-1:0]         r_x  [0:FRAC_W];
  logic [FRAC_W-1:0]     f_x  [0:FRAC_W];
  logic signed [IPW-1:0] ip_x [0:FRAC_W];
  logic                  hi_x [0:FRAC_W];
  logic                  lo_x [0:FRAC_W];
  logic [MW-1:0]         r_n2 [1:FRAC_W];
  // Scaling and clamping.
  logic [VWIDE_W-1:0]    v_X;
  logic [VWIDE_W-1:0]    v_s;
  logic [VWIDE_W-1:0]    v_c;
  logic [VWIDE_W-1:0]    floor8, ceil8;

  always_comb begin
    ca = signed'(LOGS[in_pick.row][0]);
    cb = signed'(LOGS[in_pick.row][1]);
    cc = signed'(LOGS[in_pick.row][2]);
    cd = signed'(LOGS[in_pick.row][3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    sb[0] <= '{tag: in_tag, mode: in_pick.mode};
    for (int i = 1; i < NST; i++) sb[i] <= sb[i-1];
  end

  always_ff @(posedge clk) begin
    a_A   <= ca;
    ba_A  <= DW'(cb) - DW'(ca);
    df_A  <= DW'(in_lg) - DW'(cc);
    den_A <= DW'(cd) - DW'(cc);

    a_M    <= a_A;
    prod_M <= ba_A * df_A;
    den_M  <= den_A;
    dpos_M <= (den_A > 0);

    neg_d[0]  <= prod_M[PW-1];
    x_d[0]    <= prod_M[PW-1] ? PW'(-prod_M) : PW'(prod_M);
    r_d[0]    <= '0;
    den_d[0]  <= DW'(den_M);
    a_d[0]    <= a_M;
    dpos_d[0] <= dpos_M;
  end

  // Restoring division, one quotient bit per stage; the quotient shifts in
  // behind the numerator bits as they are used up.
  for (genvar k = 1; k <= PW; k++) begin : g_div
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;
    assign trial = {r_d[k-1], x_d[k-1][PW-1]};
    assign ge = (trial >= {1'b0, den_d[k-1]});
    assign diff = trial - {1'b0, den_d[k-1]};
    assign r_n[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign x_n[k] = {x_d[k-1][PW-2:0], ge};

    always_ff @(posedge clk) begin
      x_d[k]    <= x_n[k];
      r_d[k]    <= r_n[k];
      den_d[k]  <= den_d[k-1];
      a_d[k]    <= a_d[k-1];
      neg_d[k]  <= neg_d[k-1];
      dpos_d[k] <= dpos_d[k-1];
    end
  end

  always_comb begin
    qv = signed'(EW'(x_d[PW]));
    if (neg_d[PW]) qv = -qv;
  end

  always_ff @(posedge clk) begin
    e_E <= dpos_d[PW] ? qv + EW'(a_d[PW]) : EW'(a_d[PW]);

    hi_x[0] <= (e_E >= E_HI);
    lo_x[0] <= (e_E < E_LO);
    ip_x[0] <= e_E[FRAC_W+IPW-1:FRAC_W];
    f_x[0]  <= e_E[FRAC_W-1:0];
    r_x[0]  <= MW'(1) << 30;
  end

  // Fraction bits from the top multiply in 2^(2^-k).
  for (genvar k = 1; k <= FRAC_W; k++) begin : g_exp
    localparam logic [MW-1:0] ROOT = root_q30(k);
    logic [2*MW-1:0] pr;
    assign pr = r_x[k-1] * ROOT;
    assign r_n2[k] = f_x[k-1][FRAC_W-k] ? pr[2*MW-2:MW-1] : r_x[k-1];

    always_ff @(posedge clk) begin
      r_x[k]  <= r_n2[k];
      f_x[k]  <= f_x[k-1];
      ip_x[k] <= ip_x[k-1];
      hi_x[k] <= hi_x[k-1];
      lo_x[k] <= lo_x[k-1];
    end
  end

  always_comb begin
    if (hi_x[FRAC_W]) begin
      v_s = '1;
    end else if (lo_x[FRAC_W]) begin
      v_s = '0;
    end else if (ip_x[FRAC_W] >= IP_SHIFT) begin
      v_s = VWIDE_W'(r_x[FRAC_W]) << IPW'(ip_x[FRAC_W] - IP_SHIFT);
    end else begin
      v_s = VWIDE_W'(r_x[FRAC_W]) >> IPW'(IP_SHIFT - ip_x[FRAC_W]);
    end
  end

  always_comb begin
    floor8 = VWIDE_W'({vs30_floor, 8'b0});
    ceil8  = VWIDE_W'({vs30_ceiling, 8'b0});
    v_c = (sb[X1S].mode == MODE_BELOW && sb[X1S].tag.zero) ? '0 : v_X;
    if (sb[X1S].mode == MODE_BELOW && v_c < floor8) v_c = floor8;
    if (sb[X1S].mode == MODE_ABOVE && v_c > ceil8) v_c = ceil8;
    if (v_c > VWIDE_W'(Q8_CAP)) v_c = VWIDE_W'(Q8_CAP);
  end

  always_ff @(posedge clk) begin
    v_X   <= v_s;
    out_v <= v_c[VQ8_W-1:0];
  end

  assign out_valid = vld[NST-1];
  assign out_tag   = sb[NST-1].tag;

endmodule

/* src/slope_to_vs30_loglog_blend_top.sv */
// Top level: configuration registers, front end, queue, two lanes and the output blend.
//
// Usage. A pixel (slope, land_flag, craton_weight) is taken at a rising edge
// where start is high and busy is low. Each pixel gives exactly one vs30
// result, shown for one cycle with done high; results come out in input
// order and the receiver cannot hold them off.
// From the accepting edge to the cycle in which done is high, a pixel passes
// the front end (input register, sixteen squaring stages of the log, log
// register, row select), the queue, each lane (mostly the 48-stage divider
// and sixteen exp2 multiply stages) and the blend and output register.
// Throughput is one pixel per cycle; every stage is pipelined and the lanes
// never stall, so busy stays low in normal use.
// The configuration channel (cfg_valid, cfg_ready, cfg_addr, cfg_data) is
// always ready; a transaction to an unknown index is dropped. Registers are
// sampled as results pass, so write them only while no pixel is in flight.
// Synchronous reset clears the pipeline and loads water 600, floor 180 and
// ceiling 900 m/s.
module slope_to_vs30_loglog_blend_top #(
  parameter int TABLE_ROWS = s2v_pkg::TABLE_ROWS_DEF,
  parameter int FIFO_DEPTH = s2v_pkg::Q_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [s2v_pkg::SLOPE_W-1:0]     slope,
  input  logic                            land_flag,
  input  logic [s2v_pkg::WEIGHT_W-1:0]    craton_weight,
  output logic                            done,
  output logic [s2v_pkg::VS_W-1:0]        vs30,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [s2v_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [s2v_pkg::CFG_W-1:0]       cfg_data
);
  import s2v_pkg::*;

  localparam int PRODW = WEIGHT_W + VQ8_W;
  localparam int SUMW  = PRODW + 1;
  localparam logic [SUMW-1:0] ROUND_HALF = SUMW'(1) << 19;

  logic [CFG_W-1:0] water_vs30, vs30_floor, vs30_ceiling;

  logic   adv, f_valid, q_push, q_pop, q_full, q_empty;
  item_t  f_item, q_item;

  logic              cr_valid, ac_valid;
  tag_t              cr_tag, ac_tag;
  logic [VQ8_W-1:0]  cr_v, ac_v;

  logic              pv, pland;
  logic [PRODW-1:0]  mc, ma;
  logic [SUMW-1:0]   sum;
  logic [VS_W+1:0]   scaled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      water_vs30   <= WATER_RST;
      vs30_floor   <= FLOOR_RST;
      vs30_ceiling <= CEIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_WATER: water_vs30   <= cfg_data;
        REG_FLOOR: vs30_floor   <= cfg_data;
        REG_CEIL:  vs30_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // The lanes take an item every cycle, so the queue drains as fast as it fills.
  assign q_pop  = !q_empty;
  assign adv    = !q_full || q_pop;
  assign q_push = f_valid && adv;

  s2v_front #(.TABLE_ROWS(TABLE_ROWS)) u_front (
    .clk(clk), .rst(rst), .start(start), .slope(slope), .land_flag(land_flag),
    .craton_weight(craton_weight), .adv(adv), .busy(busy),
    .out_valid(f_valid), .out_item(f_item)
  );

  s2v_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .din(f_item), .pop(q_pop),
    .dout(q_item), .full(q_full), .empty(q_empty)
  );

  s2v_lane #(.ACTIVE(1'b0)) u_lane_cr (
    .clk(clk), .rst(rst), .in_valid(q_pop), .in_tag(q_item.tag), .in_lg(q_item.lg),
    .in_pick(q_item.pick_cr), .vs30_floor(vs30_floor), .vs30_ceiling(vs30_ceiling),
    .out_valid(cr_valid), .out_tag(cr_tag), .out_v(cr_v)
  );

  s2v_lane #(.ACTIVE(1'b1)) u_lane_ac (
    .clk(clk), .rst(rst), .in_valid(q_pop), .in_tag(q_item.tag), .in_lg(q_item.lg),
    .in_pick(q_item.pick_ac), .vs30_floor(vs30_floor), .vs30_ceiling(vs30_ceiling),
    .out_valid(ac_valid), .out_tag(ac_tag), .out_v(ac_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      pv   <= cr_valid;
      done <= pv;
    end
  end

  always_ff @(posedge clk) begin
    pland <= cr_tag.land;
    mc    <= cr_tag.weight * cr_v;
    ma    <= (WEIGHT_ONE - cr_tag.weight) * ac_v;
    vs30  <= pland ? ((scaled > (VS_W+2)'({VS_W{1'b1}})) ? '1 : scaled[VS_W-1:0])
                   : {water_vs30, 4'b0};
  end

  always_comb begin
    sum    = SUMW'(mc) + SUMW'(ma) + ROUND_HALF;
    scaled = sum[SUMW-1:20];
  end

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_full || q_pop))
    else $error("pixel queue written while full");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    cr_valid == ac_valid)
    else $error("table lanes out of step");

  a_lane_tags_match: assert property (@(posedge clk) disable iff (rst)
    cr_valid |-> (ac_tag == cr_tag))
    else $error("table lanes carry different pixels");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("front end stalled although the lanes never stall");

endmodule
